// ===== hw/rtl/nrwc_pkg.sv =====
package nrwc_pkg;

	// Default sizing of the nonce and of the replay window.
	localparam int NONCE_BYTES_DEF = 7;
	localparam int WINDOW_BITS_DEF = 64;

	// Register reset values.
	localparam logic        ROLE_RST     = 1'b0;
	localparam logic [6:0]  LIMIT_RST    = 7'd64;
	localparam logic [30:0] TIME_RST     = 31'd10000;
	localparam logic [31:0] DEADLINE_RST = 32'hFFFF_FFFF;

	// Register indexes on the configuration port (byte address is four times the index).
	localparam logic [1:0] REG_ROLE     = 2'd0;
	localparam logic [1:0] REG_LIMIT    = 2'd1;
	localparam logic [1:0] REG_TIME     = 2'd2;
	localparam logic [1:0] REG_DEADLINE = 2'd3;

	// Item actions.
	localparam logic ACT_SEND    = 1'b0;
	localparam logic ACT_RECEIVE = 1'b1;

	// Verdict codes.
	localparam logic [3:0] VERDICT_SENT      = 4'd0;
	localparam logic [3:0] VERDICT_NEW       = 4'd1;
	localparam logic [3:0] VERDICT_REORDERED = 4'd2;
	localparam logic [3:0] VERDICT_DUPLICATE = 4'd3;
	localparam logic [3:0] VERDICT_SHORT     = 4'd4;
	localparam logic [3:0] VERDICT_EXPIRED   = 4'd5;
	localparam logic [3:0] VERDICT_PARITY    = 4'd6;
	localparam logic [3:0] VERDICT_STALE     = 4'd7;
	localparam logic [3:0] VERDICT_AUTH_FAIL = 4'd8;

	typedef struct packed {
		logic        action;
		logic [55:0] rx_nonce;
		logic [15:0] pkt_len;
		logic        auth_ok;
		logic [31:0] time_ms;
	} nrwc_cmd_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic [55:0] tx_nonce;
	} nrwc_res_t;

endpackage

// ===== hw/rtl/nonce_replay_window_check_core.sv =====
// Channel  Direction  Handshake                    Payload
// cmd      in         cmd_valid / cmd_stall        nrwc_cmd_t (action, rx_nonce, pkt_len, ...)
// res      out        res_valid / res_stall        nrwc_res_t (verdict, tx_nonce)
// cfg      in         psel/penable/pwrite/pready   paddr[3:0], pwdata/prdata 32 bits
//
// One item is accepted per cycle unless cmd_stall is high; it goes to the input stage register,
// then to the result register, from which its result is offered. All checking for an item is
// done combinationally between the two, where the session state is read and written.
// Reset loads the responder session: send nonce 2, expected nonce 1, empty window.
// A stalled result holds the input stage; the block then stalls its input only
// while both the input stage and the result register are full.
module nonce_replay_window_check_core
	import nrwc_pkg::*;
#(
	parameter int NONCE_BYTES = NONCE_BYTES_DEF,
	parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  nrwc_cmd_t   cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output nrwc_res_t   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Nonces are handled at the full nonce width; the age magnitude is one bit narrower.
	localparam int NW  = 8 * NONCE_BYTES;
	localparam int MW  = NW - 1;
	localparam int SHW = $clog2(WINDOW_BITS);
	localparam logic [WINDOW_BITS-1:0] WIN_ONE = WINDOW_BITS'(1);

	// Configuration registers.
	logic        role_q;
	logic [6:0]  limit_q;
	logic [30:0] time_lim_q;
	logic [31:0] deadline_q;

	// Session state.
	logic [NW-1:0]          send_q;
	logic [NW-1:0]          expected_q;
	logic [WINDOW_BITS-1:0] seen_q;
	logic [31:0]            last_adv_q;

	// Input stage and result register.
	logic      vld_s1;
	nrwc_cmd_t cmd_s1;
	logic      res_vld_q;
	nrwc_res_t res_q;

	logic       cfg_wr;
	logic [1:0] reg_idx;
	logic       cmd_take;
	logic       res_free;
	logic       s1_move;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_ROLE:     prdata = {31'd0, role_q};
			REG_LIMIT:    prdata = {25'd0, limit_q};
			REG_TIME:     prdata = {1'b0, time_lim_q};
			REG_DEADLINE: prdata = deadline_q;
		endcase
	end

	// The input stage may move on whenever the result register is empty or being emptied.
	assign res_free  = !res_vld_q || !res_stall;
	assign s1_move   = vld_s1 && res_free;
	assign cmd_stall = vld_s1 && !res_free;
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign res_valid = res_vld_q;
	assign res       = res_q;

	// The received nonce is cut to the nonce width before any comparison.
	logic [63:0]             rx_wide;
	logic [NW-1:0]           rx_n;
	logic [NW-1:0]           diff_fwd;
	logic [NW-1:0]           diff_back;
	logic                    ahead;
	logic [MW-1:0]           mag;
	logic [MW-1:0]           mag_m1;
	logic [SHW-1:0]          bit_idx;
	logic                    bit_in_win;
	logic                    beyond_win;
	logic [WINDOW_BITS-1:0]  bit_mask;
	logic [WINDOW_BITS-1:0]  shifted;
	logic [31:0]             elapsed;
	logic                    too_late;
	logic [6:0]              lim;
	logic [3:0]              verdict;
	logic                    do_advance;
	logic                    do_mark;

	assign rx_wide   = {8'd0, cmd_s1.rx_nonce};
	assign rx_n      = rx_wide[NW-1:0];
	assign ahead     = rx_n > expected_q;
	assign diff_fwd  = rx_n - expected_q;
	assign diff_back = expected_q - rx_n;
	assign mag       = ahead ? diff_fwd[NW-1:1] : diff_back[NW-1:1];
	assign mag_m1    = mag - MW'(1);
	assign bit_idx   = mag_m1[SHW-1:0];
	assign bit_in_win = mag_m1 < MW'(WINDOW_BITS);
	assign beyond_win = mag >= MW'(WINDOW_BITS);
	assign bit_mask  = bit_in_win ? (WIN_ONE << bit_idx) : '0;
	assign shifted   = beyond_win ? '0 : (seen_q << mag[SHW-1:0]);

	// A clock that runs behind the last advance gives a negative elapsed time: never too late.
	assign elapsed  = cmd_s1.time_ms - last_adv_q;
	assign too_late = !elapsed[31] && (elapsed[30:0] > time_lim_q);
	assign lim      = (limit_q > 7'(WINDOW_BITS)) ? 7'(WINDOW_BITS) : limit_q;

	// Checks run in order; any rejection leaves the session state untouched.
	always_comb begin
		verdict    = VERDICT_SENT;
		do_advance = 1'b0;
		do_mark    = 1'b0;
		if (cmd_s1.action == ACT_RECEIVE) begin
			priority if (cmd_s1.pkt_len < 16'(NONCE_BYTES)) begin
				verdict = VERDICT_SHORT;
			end else if (cmd_s1.time_ms >= deadline_q) begin
				verdict = VERDICT_EXPIRED;
			end else if (rx_n[0] != expected_q[0]) begin
				verdict = VERDICT_PARITY;
			end else if (!ahead && (too_late || (mag > MW'(lim)))) begin
				verdict = VERDICT_STALE;
			end else if (!cmd_s1.auth_ok) begin
				verdict = VERDICT_AUTH_FAIL;
			end else if (ahead) begin
				verdict    = VERDICT_NEW;
				do_advance = 1'b1;
			end else if (mag == '0) begin
				verdict = VERDICT_DUPLICATE;
			end else if ((seen_q & bit_mask) != '0) begin
				verdict = VERDICT_DUPLICATE;
			end else begin
				verdict = VERDICT_REORDERED;
				do_mark = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				vld_s1 <= 1'b1;
			end else if (s1_move) begin
				vld_s1 <= 1'b0;
			end
			if (s1_move) begin
				res_vld_q <= 1'b1;
			end else if (!res_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1 <= cmd;
		end
		if (s1_move) begin
			res_q.verdict <= verdict;
			if (cmd_s1.action == ACT_SEND) begin
				res_q.tx_nonce <= 56'(64'(send_q));
			end else begin
				res_q.tx_nonce <= '0;
			end
		end
	end

	// Configuration writes must come only while the block is idle (unchecked) and take priority.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q     <= ROLE_RST;
			limit_q    <= LIMIT_RST;
			time_lim_q <= TIME_RST;
			deadline_q <= DEADLINE_RST;
			send_q     <= NW'(2);
			expected_q <= NW'(1);
			seen_q     <= '0;
			last_adv_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROLE: begin
					// Writing the role opens a fresh session.
					role_q     <= pwdata[0];
					send_q     <= pwdata[0] ? NW'(3) : NW'(2);
					expected_q <= pwdata[0] ? NW'(0) : NW'(1);
					seen_q     <= '0;
					last_adv_q <= '0;
				end
				REG_LIMIT:    limit_q    <= pwdata[6:0];
				REG_TIME:     time_lim_q <= pwdata[30:0];
				REG_DEADLINE: deadline_q <= pwdata;
			endcase
		end else if (s1_move) begin
			if (cmd_s1.action == ACT_SEND) begin
				send_q <= send_q + NW'(2);
			end
			if (do_advance) begin
				// Slide the window forward and record the previous expected nonce if it is still inside it.
				seen_q     <= shifted | bit_mask;
				expected_q <= rx_n;
				last_adv_q <= cmd_s1.time_ms;
			end else if (do_mark) begin
				seen_q <= seen_q | bit_mask;
			end
		end
	end

endmodule

// ===== hw/rtl/nrwc_checker.sv =====
module nrwc_checker
	import nrwc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input nrwc_cmd_t   cmd,
	input logic        res_valid,
	input logic        res_stall,
	input nrwc_res_t   res,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// A stalled result holds still.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// The input is stalled only when a result is waiting behind a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("input stalled without output back-pressure");

	// An accepted item reaches the output once the output is free.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) ##1 (!res_valid || !res_stall) |=> res_valid)
		else $error("accepted item did not produce a result");

	// Only a send result carries a nonce, and verdicts stay within the defined codes.
	a_res_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.verdict <= VERDICT_AUTH_FAIL)
			&& ((res.verdict == VERDICT_SENT) || (res.tx_nonce == '0)))
		else $error("malformed result");

endmodule

bind nonce_replay_window_check_core nrwc_checker u_nrwc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd(cmd),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res(res),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata),
	.pready(pready)
);

// ===== tb/sv/tb_nonce_replay_window_check_core.sv =====
module tb_nonce_replay_window_check_core;
	import nrwc_pkg::*;

	// Sizing of the block under test and of the run.
	localparam int NONCE_LEN = NONCE_BYTES_DEF;
	localparam int WINDOW_LEN = WINDOW_BITS_DEF;
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASES = 5;
	localparam logic [55:0] NONCE_TOP = '1;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	nrwc_cmd_t cmd;
	logic res_valid;
	logic res_stall;
	nrwc_res_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	nonce_replay_window_check_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd     (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// Registers as the testbench believes them to be.
	logic        role_q;
	logic [6:0]  limit_q;
	logic [30:0] reorder_ms_q;
	logic [31:0] deadline_q;

	// Session state as the testbench believes it to be.
	logic [55:0] send_ctr;
	logic [55:0] exp_nonce;
	logic [63:0] seen_win;
	logic [31:0] last_adv_ms;

	// Results still owed by the block, oldest first.
	nrwc_res_t due_results[$];

	// One row of the directed table: the item, and, where the answer is plain to see,
	// the result that is typed in by hand.
	typedef struct {
		nrwc_cmd_t   item;
		logic        typed;
		logic [3:0]  verdict;
		logic [55:0] tx_nonce;
	} plan_row_t;

	plan_row_t plan[$];

	int errors = 0;
	int sends = 0;
	int receives = 0;
	int results_seen = 0;
	int settings_used = 0;
	int verdict_tally[16];
	int idle_cycles = 0;
	logic steady = 1'b0;
	logic [31:0] now_ms;
	int stall_left = 0;

	// A new session reloads both nonces for the current role and empties the window.
	function automatic void open_session();
		send_ctr = role_q ? 56'd3 : 56'd2;
		exp_nonce = role_q ? 56'd0 : 56'd1;
		seen_win = '0;
		last_adv_ms = '0;
	endfunction

	// Works out the result of one accepted item and moves the session state on,
	// exactly as the block must. The checks run in a fixed order: length, deadline,
	// parity, then staleness for packets that do not move the window forward, then
	// the MAC result, and only then the window itself.
	function automatic nrwc_res_t session_verdict(input nrwc_cmd_t c);
		nrwc_res_t   r;
		logic        ahead;
		logic [55:0] mag;
		logic [31:0] elapsed;
		logic [6:0]  lim;
		logic [63:0] win;
		logic [5:0]  slot;
		r.verdict = VERDICT_SENT;
		r.tx_nonce = '0;
		if (c.action == ACT_SEND) begin
			r.tx_nonce = send_ctr;
			send_ctr = send_ctr + 56'd2;
		end else if (c.pkt_len < 16'(NONCE_LEN)) begin
			r.verdict = VERDICT_SHORT;
		end else if (c.time_ms >= deadline_q) begin
			r.verdict = VERDICT_EXPIRED;
		end else if (c.rx_nonce[0] != exp_nonce[0]) begin
			r.verdict = VERDICT_PARITY;
		end else begin
			ahead = c.rx_nonce > exp_nonce;
			mag = ahead ? (c.rx_nonce - exp_nonce) >> 1 : (exp_nonce - c.rx_nonce) >> 1;
			// A clock that has gone backwards gives a negative elapsed time, which
			// never counts as stale.
			elapsed = c.time_ms - last_adv_ms;
			lim = (limit_q > 7'(WINDOW_LEN)) ? 7'(WINDOW_LEN) : limit_q;
			slot = mag[5:0] - 6'd1;
			if (!ahead && ((!elapsed[31] && elapsed > {1'b0, reorder_ms_q}) || mag > 56'(lim))) begin
				r.verdict = VERDICT_STALE;
			end else if (!c.auth_ok) begin
				r.verdict = VERDICT_AUTH_FAIL;
			end else if (ahead) begin
				// The window slides by the advance; the slot of the old expected
				// nonce survives only if it still lies inside the window.
				win = (mag >= 56'(WINDOW_LEN)) ? 64'd0 : seen_win << mag;
				if (mag <= 56'(WINDOW_LEN))
					win[slot] = 1'b1;
				seen_win = win;
				exp_nonce = c.rx_nonce;
				last_adv_ms = c.time_ms;
				r.verdict = VERDICT_NEW;
			end else if (mag == 56'd0 || seen_win[slot]) begin
				r.verdict = VERDICT_DUPLICATE;
			end else begin
				seen_win[slot] = 1'b1;
				r.verdict = VERDICT_REORDERED;
			end
		end
		return r;
	endfunction

	function automatic nrwc_cmd_t receive_item(input logic [55:0] nonce, input logic [15:0] len,
			input logic auth, input logic [31:0] stamp);
		nrwc_cmd_t c;
		c.action = ACT_RECEIVE;
		c.rx_nonce = nonce;
		c.pkt_len = len;
		c.auth_ok = auth;
		c.time_ms = stamp;
		return c;
	endfunction

	// A send item with its unused fields filled with all ones or with all zeros.
	function automatic nrwc_cmd_t send_item(input logic ones);
		nrwc_cmd_t c;
		c = ones ? '1 : '0;
		c.action = ACT_SEND;
		return c;
	endfunction

	function automatic void add_row(input nrwc_cmd_t item, input logic typed,
			input logic [3:0] verdict, input logic [55:0] tx_nonce);
		plan_row_t row;
		row.item = item;
		row.typed = typed;
		row.verdict = verdict;
		row.tx_nonce = tx_nonce;
		plan.push_back(row);
	endfunction

	// Idle stretches: mostly none or short, now and then long, and none at all
	// while the run is in one of its steady stretches.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Random items are mostly well-formed traffic near the expected nonce, so that
	// the window really fills, slides and catches duplicates; the rest is wrong
	// parity, short packets, failed MACs, send items and nonces drawn from the whole range.
	function automatic nrwc_cmd_t random_item();
		nrwc_cmd_t   c;
		logic [63:0] noise;
		int          pick;
		int          step;
		noise = {$urandom, $urandom};
		c.action = ACT_RECEIVE;
		c.rx_nonce = noise[55:0];
		c.pkt_len = 16'($urandom_range(NONCE_LEN, 16'hFFFF));
		c.auth_ok = ($urandom_range(0, 15) != 0);
		pick = $urandom_range(0, 99);
		if (pick >= 30 && pick < 80)
			now_ms = now_ms + $urandom_range(1, 400);
		else if (pick >= 80 && pick < 90)
			now_ms = now_ms + $urandom_range(5000, 15000);
		else if (pick >= 90 && pick < 95)
			now_ms = now_ms - $urandom_range(0, 3000);
		c.time_ms = (pick >= 97) ? $urandom : now_ms;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			c.action = ACT_SEND;
		end else if (pick < 45) begin
			step = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 3);
			c.rx_nonce = exp_nonce + 56'(2 * step);
		end else if (pick < 75) begin
			c.rx_nonce = exp_nonce - 56'(2 * $urandom_range(0, 70));
		end else if (pick < 82) begin
			c.rx_nonce = exp_nonce + 56'(2 * $urandom_range(0, 8) + 1);
		end else if (pick < 88) begin
			c.rx_nonce = exp_nonce;
			c.pkt_len = 16'($urandom_range(0, NONCE_LEN - 1));
		end else begin
			c.pkt_len = 16'($urandom);
		end
		return c;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("error: result %0d, %s is %0h but %0h was predicted", results_seen, field,
			got, want);
	endtask

	// Offers one item and waits until the block takes it. The valid stays high on
	// return, so the next call either replaces the item at once or drops the valid.
	task automatic offer_item(input nrwc_cmd_t item, input logic typed, input nrwc_res_t typed_res);
		int gap;
		nrwc_res_t due;
		gap = draw_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= item;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		due = session_verdict(item);
		if (typed)
			due = typed_res;
		due_results.push_back(due);
		if (item.action == ACT_SEND)
			sends++;
		else
			receives++;
	endtask

	// Stops offering items and waits for every owed result, so that the block is fully
	// idle.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write: a setup phase, then an access phase held until pready.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ROLE: begin
				// A role write starts a fresh session.
				role_q = value[0];
				open_session();
			end
			REG_LIMIT: limit_q = value[6:0];
			REG_TIME: reorder_ms_q = value[30:0];
			REG_DEADLINE: deadline_q = value;
			default: ;
		endcase
	endtask

	// Result side: check each accepted result against the oldest one owed, then
	// decide whether to stall the next cycle.
	always @(posedge clk) begin
		nrwc_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing owed, verdict", 64'(res.verdict), 64'd0);
			end else begin
				want = due_results.pop_front();
				if (res.verdict !== want.verdict)
					report_mismatch("verdict", 64'(res.verdict), 64'(want.verdict));
				if (res.tx_nonce !== want.tx_nonce)
					report_mismatch("tx_nonce", 64'(res.tx_nonce), 64'(want.tx_nonce));
				verdict_tally[want.verdict]++;
			end
		end
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else begin
			res_stall <= 1'b0;
			stall_left = draw_gap();
		end
	end

	// Watchdog: any handshake or register access counts as progress.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no progress for %0d cycles", IDLE_LIMIT);
			$display("nonce_replay_window_check_core: mismatch");
			$finish;
		end
	end

	initial begin
		logic        phase_role[PHASES];
		logic [6:0]  phase_limit[PHASES];
		logic [30:0] phase_time[PHASES];
		int          phase_items[PHASES];
		logic [31:0] deadline;
		nrwc_res_t   typed_res;
		int          i;
		int          p;

		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (verdict_tally[k])
			verdict_tally[k] = 0;

		role_q = ROLE_RST;
		limit_q = LIMIT_RST;
		reorder_ms_q = TIME_RST;
		deadline_q = DEADLINE_RST;
		open_session();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, straight after reset (responder, send nonce 2, expected 1).
		// Error verdicts and all send nonces are typed in; the rest follow
		// from the session state and are left to the predictor.
		add_row(send_item(1'b0), 1'b1, VERDICT_SENT, 56'd2);
		add_row(send_item(1'b1), 1'b1, VERDICT_SENT, 56'd4);
		add_row(receive_item(56'd1, 16'd0, 1'b1, 32'd0), 1'b1, VERDICT_SHORT, '0);
		add_row(receive_item(56'd1, 16'd6, 1'b1, 32'd0), 1'b1, VERDICT_SHORT, '0);
		// The deadline is exclusive: the last millisecond is already past it.
		add_row(receive_item(56'd1, 16'd7, 1'b1, 32'hFFFF_FFFF), 1'b1, VERDICT_EXPIRED, '0);
		add_row(receive_item(56'd0, 16'd7, 1'b1, 32'd0), 1'b1, VERDICT_PARITY, '0);
		add_row(receive_item(56'd1, 16'd64, 1'b1, 32'd0), 1'b1, VERDICT_DUPLICATE, '0);
		add_row(receive_item(56'd1, 16'd64, 1'b0, 32'd0), 1'b1, VERDICT_AUTH_FAIL, '0);
		add_row(receive_item(56'd3, 16'd64, 1'b1, 32'd100), 1'b0, VERDICT_SENT, '0);
		add_row(receive_item(56'd1, 16'd64, 1'b1, 32'd200), 1'b0, VERDICT_SENT, '0);
		// An advance of more than a whole window empties it.
		add_row(receive_item(56'd143, 16'd1500, 1'b1, 32'd300), 1'b0, VERDICT_SENT, '0);
		// Oldest slot still inside the window, then one beyond it.
		add_row(receive_item(56'd15, 16'd1500, 1'b1, 32'd300), 1'b0, VERDICT_SENT, '0);
		add_row(receive_item(56'd13, 16'd1500, 1'b1, 32'd300), 1'b1, VERDICT_STALE, '0);
		// An advance of exactly one window keeps only the old expected slot.
		add_row(receive_item(56'd271, 16'd1500, 1'b1, 32'd400), 1'b0, VERDICT_SENT, '0);
		// The clock has gone backwards here, which must not make the packet stale.
		add_row(receive_item(56'd269, 16'd1500, 1'b1, 32'd100), 1'b0, VERDICT_SENT, '0);
		add_row(receive_item(56'd267, 16'd1500, 1'b1, 32'd10401), 1'b1, VERDICT_STALE, '0);
		add_row(receive_item(56'd267, 16'd1500, 1'b1, 32'd10400), 1'b0, VERDICT_SENT, '0);
		// The top of the nonce range, a packet just behind it, and then one far behind it.
		add_row(receive_item(NONCE_TOP, 16'hFFFF, 1'b1, 32'd10400), 1'b0, VERDICT_SENT, '0);
		add_row(receive_item(NONCE_TOP - 56'd2, 16'd7, 1'b1, 32'd10400), 1'b0, VERDICT_SENT, '0);
		add_row(receive_item(56'd1, 16'd7, 1'b1, 32'd10400), 1'b1, VERDICT_STALE, '0);
		add_row(receive_item(NONCE_TOP, 16'd7, 1'b0, 32'd10400), 1'b1, VERDICT_AUTH_FAIL, '0);
		add_row(send_item(1'b1), 1'b1, VERDICT_SENT, 56'd6);

		settings_used = 1;
		foreach (plan[r]) begin
			typed_res.verdict = plan[r].verdict;
			typed_res.tx_nonce = plan[r].tx_nonce;
			offer_item(plan[r].item, plan[r].typed, typed_res);
		end

		// Random part, one phase per register setting. Every register is written
		// in every phase, and between them the extremes of each are visited:
		// both roles, a limit of zero and one far above the window, no reorder time
		// and the largest one, and a deadline that is already past.
		phase_role = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		phase_limit = '{7'd0, 7'd127, 7'd40, 7'd64, 7'd64};
		phase_time = '{31'h7FFF_FFFF, 31'd0, 31'd3000, 31'd10000, 31'd10000};
		phase_items = '{120, 80, 150, 30, 80};

		for (p = 0; p < PHASES; p++) begin
			drain();
			now_ms = $urandom_range(0, 2000);
			if (p == 2)
				deadline = now_ms + 32'd30000;
			else if (p == 3)
				deadline = 32'd0;
			else
				deadline = 32'hFFFF_FFFF;
			write_reg(REG_ROLE, {31'd0, phase_role[p]});
			write_reg(REG_LIMIT, {25'd0, phase_limit[p]});
			write_reg(REG_TIME, {1'b0, phase_time[p]});
			write_reg(REG_DEADLINE, deadline);
			settings_used++;
			for (i = 0; i < phase_items[p]; i++) begin
				// Every third stretch of 32 items draws no idle gaps and no output stalls.
				steady = ((i / 32) % 3 == 1);
				// Once in the first phase the sender holds off until the block
				// has returned everything it owes.
				if (p == 0 && i == 60)
					drain();
				offer_item(random_item(), 1'b0, typed_res);
			end
			steady = 1'b0;
		end

		drain();
		repeat (10) @(posedge clk);

		$display("Run covered %0d send and %0d receive items under %0d register settings.",
			sends, receives, settings_used);
		$display("Verdicts: new %0d, reordered %0d, duplicate %0d, rejected %0d.",
			verdict_tally[VERDICT_NEW], verdict_tally[VERDICT_REORDERED],
			verdict_tally[VERDICT_DUPLICATE],
			receives - verdict_tally[VERDICT_NEW] - verdict_tally[VERDICT_REORDERED]
				- verdict_tally[VERDICT_DUPLICATE]);
		if (errors == 0)
			$display("nonce_replay_window_check_core: match");
		else
			$display("nonce_replay_window_check_core: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/nrwc_pkg.sv
hw/rtl/nonce_replay_window_check_core.sv
hw/rtl/nrwc_checker.sv
tb/sv/tb_nonce_replay_window_check_core.sv
